[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

[rtl/btwag_pkg.sv]
// ----------------------------------------------------------------------------
// btwag_pkg
// Types and constants shared by the tile write-back address generator.
// ----------------------------------------------------------------------------
`default_nettype none

package btwag_pkg;

  localparam int unsigned PAGE_W     = 34;  // linear page id
  localparam int unsigned SLOT_W     = 6;   // slot within a subblock
  localparam int unsigned TDIM_W     = 13;  // Mt, Nt, blocks per row
  localparam int unsigned BDIM_W     = 11;  // batch count, block height/width
  localparam int unsigned BIDX_W     = 16;  // first block, block count
  localparam int unsigned AREA_W     = 2 * TDIM_W;
  localparam int unsigned ROW_ORG_W  = 29;  // block row origin, tile row
  localparam int unsigned COL_ORG_W  = 24;  // block column origin, tile column
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_TILE_ROWS  = 3'd0,
    CFG_TILE_COLS  = 3'd1,
    CFG_BATCHES    = 3'd2,
    CFG_BLK_HEIGHT = 3'd3,
    CFG_BLK_WIDTH  = 3'd4,
    CFG_BLK_PER_ROW = 3'd5,
    CFG_FIRST_BLK  = 3'd6,
    CFG_BLK_COUNT  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [TDIM_W-1:0] tile_rows_total;
    logic [TDIM_W-1:0] tile_cols_total;
    logic [BDIM_W-1:0] batch_count;
    logic [BDIM_W-1:0] block_height;
    logic [BDIM_W-1:0] block_width;
    logic [TDIM_W-1:0] blocks_per_row;
    logic [BIDX_W-1:0] first_block;
    logic [BIDX_W-1:0] block_count;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_DIV,
    ST_ORIGIN,
    ST_IDLE,
    ST_START,
    ST_MUL,
    ST_ADD,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic clear;        // reset walk counters, latch Mt*Nt
    logic div_start;    // split first block into row and column
    logic load_origin;  // origins of the first block from the quotient and remainder
    logic tile_start;   // subblock corner
    logic mul;          // corner row times Nt
    logic add;          // page of the corner
    logic emit;         // load one tile into the output stage
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic tile_last;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/blocked_tile_writeback_address_gen.sv]
// ----------------------------------------------------------------------------
// blocked_tile_writeback_address_gen
// Output tile write-back address generator for a blocked matrix product.
// ----------------------------------------------------------------------------
// Each beat on the slave stream with bit 0 set announces one ready subblock
// of SUB_H x SUB_W tiles; the block answers with SUB_H*SUB_W beats, one per
// tile slot in row-major order, carrying the destination page id, the write
// enable (tuser), the slot index and job-done flag (tdata) and the last slot
// of the subblock (tlast). Each accepted subblock first runs corner setup
// (subblock corner, multiply by Nt, page add) and then issues its tiles
// through the single output register, holding while the master side stalls;
// the next beat is taken only once the last tile is issued. Any config write
// restarts the walk; the restart splits first_block over blocks_per_row in a
// bit-serial divider and holds the slave side off until the origins are loaded.
`default_nettype none

module blocked_tile_writeback_address_gen
  import btwag_pkg::*;
#(
  parameter int unsigned SUB_H = 2,
  parameter int unsigned SUB_W = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // slave stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // [0] subblock_ready
  // master stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [47:0]                m_axis_tdata,   // [33:0] page_id, [39:34] slot_index,
                                                     // [40] job_done
  output logic                       m_axis_tlast,   // subblock_last
  output logic                       m_axis_tuser,   // write_enable
  // config write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t              cfg_q, cfg_d;
  logic              cfg_we;
  logic [TDIM_W-1:0] bpr_eff;
  ctrl_cmd_t         cmd;
  dp_status_t        status;
  logic              div_done;
  logic [BIDX_W-1:0] div_quot;
  logic [TDIM_W-1:0] div_rem;
  logic              out_we;
  logic [PAGE_W-1:0] out_page;
  logic [SLOT_W-1:0] out_slot;
  logic              out_job;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_TILE_ROWS:   cfg_d.tile_rows_total = cfg_data_i[TDIM_W-1:0];
        CFG_TILE_COLS:   cfg_d.tile_cols_total = cfg_data_i[TDIM_W-1:0];
        CFG_BATCHES:     cfg_d.batch_count     = cfg_data_i[BDIM_W-1:0];
        CFG_BLK_HEIGHT:  cfg_d.block_height    = cfg_data_i[BDIM_W-1:0];
        CFG_BLK_WIDTH:   cfg_d.block_width     = cfg_data_i[BDIM_W-1:0];
        CFG_BLK_PER_ROW: cfg_d.blocks_per_row  = cfg_data_i[TDIM_W-1:0];
        CFG_FIRST_BLK:   cfg_d.first_block     = cfg_data_i[BIDX_W-1:0];
        CFG_BLK_COUNT:   cfg_d.block_count     = cfg_data_i[BIDX_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tile_rows_total <= TDIM_W'(1);
      cfg_q.tile_cols_total <= TDIM_W'(1);
      cfg_q.batch_count     <= BDIM_W'(1);
      cfg_q.block_height    <= BDIM_W'(2);
      cfg_q.block_width     <= BDIM_W'(4);
      cfg_q.blocks_per_row  <= TDIM_W'(1);
      cfg_q.first_block     <= '0;
      cfg_q.block_count     <= BIDX_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // zero blocks per row acts as one
  assign bpr_eff = (cfg_q.blocks_per_row == '0) ? TDIM_W'(1) : cfg_q.blocks_per_row;

  btwag_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_bit_i (s_axis_tdata[0]),
    .in_ready_o     (s_axis_tready),
    .div_done_i     (div_done),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  btwag_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd.div_start),
    .dividend_i (cfg_q.first_block),
    .divisor_i  (bpr_eff),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  btwag_dp #(
    .SUB_H (SUB_H),
    .SUB_W (SUB_W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .bpr_eff_i   (bpr_eff),
    .div_quot_i  (div_quot),
    .div_rem_i   (div_rem),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_we_o    (out_we),
    .out_page_o  (out_page),
    .out_slot_o  (out_slot),
    .out_last_o  (m_axis_tlast),
    .out_job_o   (out_job)
  );

  assign m_axis_tuser = out_we;
  assign m_axis_tdata = {7'b0, out_job, out_slot, out_page};

endmodule

`default_nettype wire

[rtl/btwag_div.sv]
// ----------------------------------------------------------------------------
// btwag_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module btwag_div
  import btwag_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [BIDX_W-1:0] dividend_i,
  input  wire logic [TDIM_W-1:0] divisor_i,
  output logic                   done_o,
  output logic [BIDX_W-1:0]      quot_o,
  output logic [TDIM_W-1:0]      rem_o
);

  localparam int unsigned CNT_W = $clog2(BIDX_W + 1);

  logic [BIDX_W-1:0] quot_q, quot_d;
  logic [TDIM_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [TDIM_W:0]   trial;
  logic [TDIM_W:0]   dvs;
  logic              fits;

  assign trial = {rem_q, quot_q[BIDX_W-1]};
  assign dvs   = {1'b0, divisor_i};
  assign fits  = trial >= dvs;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(BIDX_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? TDIM_W'(trial - dvs) : trial[TDIM_W-1:0];
      quot_d = {quot_q[BIDX_W-2:0], fits};
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

[rtl/btwag_ctrl.sv]
// ----------------------------------------------------------------------------
// btwag_ctrl
// Sequencer: restart after config, then per subblock corner setup and
// one tile emission per free output slot.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module btwag_ctrl
  import btwag_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       in_valid_i,
  input  wire logic       in_ready_bit_i,
  output logic            in_ready_o,
  input  wire logic       div_done_i,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.clear     = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (div_done_i) state_d = ST_ORIGIN;
      end
      ST_ORIGIN: begin
        cmd_o.load_origin = 1'b1;
        state_d           = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        // a beat with the ready bit clear is consumed and does nothing
        if (in_valid_i && in_ready_bit_i) state_d = ST_START;
      end
      ST_START: begin
        cmd_o.tile_start = 1'b1;
        state_d          = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.tile_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
    if (cfg_we_i) state_d = ST_INIT;
  end

  `ASSERT_IMPLY(a_emit_free, clk_i, rst_ni, cmd_o.emit, status_i.out_free,
                "tile emitted into a busy output stage")
  `ASSERT_NEXT(a_start_follows, clk_i, rst_ni,
               in_ready_o && in_valid_i && in_ready_bit_i && !cfg_we_i,
               state_q == ST_START, "accepted subblock did not start")
  `ASSERT_NEXT(a_cfg_restart, clk_i, rst_ni, cfg_we_i, state_q == ST_INIT,
               "config write did not restart the walk")

endmodule

`default_nettype wire

[rtl/btwag_dp.sv]
// ----------------------------------------------------------------------------
// btwag_dp
// Walk counters, block origins, tile address arithmetic and output stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module btwag_dp
  import btwag_pkg::*;
#(
  parameter int unsigned SUB_H = 2,
  parameter int unsigned SUB_W = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic [TDIM_W-1:0] bpr_eff_i,
  input  wire logic [BIDX_W-1:0] div_quot_i,
  input  wire logic [TDIM_W-1:0] div_rem_i,
  input  wire ctrl_cmd_t         cmd_i,
  output dp_status_t             status_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic                   out_we_o,
  output logic [PAGE_W-1:0]      out_page_o,
  output logic [SLOT_W-1:0]      out_slot_o,
  output logic                   out_last_o,
  output logic                   out_job_o
);

  localparam int unsigned H_W  = (SUB_H > 1) ? $clog2(SUB_H) : 1;
  localparam int unsigned W_W  = (SUB_W > 1) ? $clog2(SUB_W) : 1;
  localparam int unsigned OFF_W = BDIM_W + 1;

  // walk state
  logic [BDIM_W-1:0]    batch_q, batch_d;
  logic [BIDX_W-1:0]    blk_off_q, blk_off_d;
  logic [BDIM_W-1:0]    row_off_q, row_off_d;   // subblock row * SUB_H
  logic [BDIM_W-1:0]    col_off_q, col_off_d;   // subblock col * SUB_W
  logic [PAGE_W-1:0]    base_q, base_d;
  logic [AREA_W-1:0]    area_q, area_d;
  logic [TDIM_W-1:0]    rem_q, rem_d, rem0_q, rem0_d;
  logic [ROW_ORG_W-1:0] row_org_q, row_org_d, row_org0_q, row_org0_d;
  logic [COL_ORG_W-1:0] col_org_q, col_org_d, col_org0_q, col_org0_d;
  // per subblock
  logic [ROW_ORG_W-1:0] m0_q, m0_d;
  logic [COL_ORG_W-1:0] n0_q, n0_d;
  logic [PAGE_W-1:0]    prod_q, prod_d;
  logic [PAGE_W-1:0]    row_page_q, row_page_d;
  logic [H_W-1:0]       h_q, h_d;
  logic [W_W-1:0]       w_q, w_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  // output stage
  logic                 out_valid_q, out_valid_d;
  logic                 out_we_q, out_we_d;
  logic [PAGE_W-1:0]    out_page_q, out_page_d;
  logic [SLOT_W-1:0]    out_slot_q, out_slot_d;
  logic                 out_last_q, out_last_d;
  logic                 out_job_q, out_job_d;

  logic [BIDX_W-1:0]    blk_cnt_eff;
  logic [BDIM_W-1:0]    bat_cnt_eff;
  logic                 col_end, row_end, blk_end, bat_end, done;
  logic [TDIM_W:0]      rem_inc;
  logic [ROW_ORG_W-1:0] m_cur;
  logic [COL_ORG_W-1:0] n_cur;
  logic [PAGE_W-1:0]    page_cur;
  logic                 we_cur;
  logic                 tile_last;
  logic [ROW_ORG_W+TDIM_W-1:0] prod_full;

  assign blk_cnt_eff = (cfg_i.block_count == '0) ? BIDX_W'(1) : cfg_i.block_count;
  assign bat_cnt_eff = (cfg_i.batch_count == '0) ? BDIM_W'(1) : cfg_i.batch_count;

  // floor(dim / SUB) <= off/SUB + 1, with a floor of zero counted as one
  assign col_end = {1'b0, cfg_i.block_width} < ({1'b0, col_off_q} + OFF_W'(2 * SUB_W));
  assign row_end = {1'b0, cfg_i.block_height} < ({1'b0, row_off_q} + OFF_W'(2 * SUB_H));
  assign blk_end = ({1'b0, blk_off_q} + (BIDX_W + 1)'(1)) >= {1'b0, blk_cnt_eff};
  assign bat_end = ({1'b0, batch_q} + (BDIM_W + 1)'(1)) >= {1'b0, bat_cnt_eff};
  assign done    = col_end && row_end && blk_end && bat_end;

  assign rem_inc = {1'b0, rem_q} + (TDIM_W + 1)'(1);

  assign m_cur     = m0_q + ROW_ORG_W'(h_q);
  assign n_cur     = n0_q + COL_ORG_W'(w_q);
  assign page_cur  = row_page_q + PAGE_W'(w_q);
  assign we_cur    = (m_cur < ROW_ORG_W'(cfg_i.tile_rows_total)) &&
                     (n_cur < COL_ORG_W'(cfg_i.tile_cols_total));
  assign tile_last = (h_q == H_W'(SUB_H - 1)) && (w_q == W_W'(SUB_W - 1));
  assign prod_full = m0_q * cfg_i.tile_cols_total;

  always_comb begin
    batch_d    = batch_q;
    blk_off_d  = blk_off_q;
    row_off_d  = row_off_q;
    col_off_d  = col_off_q;
    base_d     = base_q;
    area_d     = area_q;
    rem_d      = rem_q;
    rem0_d     = rem0_q;
    row_org_d  = row_org_q;
    row_org0_d = row_org0_q;
    col_org_d  = col_org_q;
    col_org0_d = col_org0_q;
    m0_d       = m0_q;
    n0_d       = n0_q;
    prod_d     = prod_q;
    row_page_d = row_page_q;
    h_d        = h_q;
    w_d        = w_q;
    slot_d     = slot_q;
    out_we_d   = out_we_q;
    out_page_d = out_page_q;
    out_slot_d = out_slot_q;
    out_last_d = out_last_q;
    out_job_d  = out_job_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cmd_i.clear) begin
      batch_d   = '0;
      blk_off_d = '0;
      row_off_d = '0;
      col_off_d = '0;
      base_d    = '0;
      area_d    = cfg_i.tile_rows_total * cfg_i.tile_cols_total;
    end

    if (cmd_i.load_origin) begin
      rem_d      = div_rem_i;
      rem0_d     = div_rem_i;
      row_org_d  = ROW_ORG_W'(div_quot_i * cfg_i.block_height);
      row_org0_d = ROW_ORG_W'(div_quot_i * cfg_i.block_height);
      col_org_d  = COL_ORG_W'(div_rem_i * cfg_i.block_width);
      col_org0_d = COL_ORG_W'(div_rem_i * cfg_i.block_width);
    end

    if (cmd_i.tile_start) begin
      m0_d   = row_org_q + ROW_ORG_W'(row_off_q);
      n0_d   = col_org_q + COL_ORG_W'(col_off_q);
      h_d    = '0;
      w_d    = '0;
      slot_d = '0;
    end

    if (cmd_i.mul) prod_d = prod_full[PAGE_W-1:0];

    if (cmd_i.add) row_page_d = base_q + prod_q + PAGE_W'(n0_q);

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_we_d    = we_cur;
      out_page_d  = we_cur ? page_cur : '0;
      out_slot_d  = slot_q;
      out_last_d  = tile_last;
      out_job_d   = tile_last && done;
      slot_d      = slot_q + SLOT_W'(1);
      if (w_q == W_W'(SUB_W - 1)) begin
        w_d        = '0;
        h_d        = h_q + H_W'(1);
        row_page_d = row_page_q + PAGE_W'(cfg_i.tile_cols_total);
      end else begin
        w_d = w_q + W_W'(1);
      end

      // step the walk once the subblock is fully issued
      if (tile_last) begin
        if (!col_end) begin
          col_off_d = col_off_q + BDIM_W'(SUB_W);
        end else begin
          col_off_d = '0;
          if (!row_end) begin
            row_off_d = row_off_q + BDIM_W'(SUB_H);
          end else begin
            row_off_d = '0;
            if (!blk_end) begin
              blk_off_d = blk_off_q + BIDX_W'(1);
              if (rem_inc == {1'b0, bpr_eff_i}) begin
                rem_d     = '0;
                col_org_d = '0;
                row_org_d = row_org_q + ROW_ORG_W'(cfg_i.block_height);
              end else begin
                rem_d     = rem_inc[TDIM_W-1:0];
                col_org_d = col_org_q + COL_ORG_W'(cfg_i.block_width);
              end
            end else begin
              blk_off_d = '0;
              rem_d     = rem0_q;
              row_org_d = row_org0_q;
              col_org_d = col_org0_q;
              if (!bat_end) begin
                batch_d = batch_q + BDIM_W'(1);
                base_d  = base_q + PAGE_W'(area_q);
              end else begin
                batch_d = '0;
                base_d  = '0;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    batch_q    <= batch_d;
    blk_off_q  <= blk_off_d;
    row_off_q  <= row_off_d;
    col_off_q  <= col_off_d;
    base_q     <= base_d;
    area_q     <= area_d;
    rem_q      <= rem_d;
    rem0_q     <= rem0_d;
    row_org_q  <= row_org_d;
    row_org0_q <= row_org0_d;
    col_org_q  <= col_org_d;
    col_org0_q <= col_org0_d;
    m0_q       <= m0_d;
    n0_q       <= n0_d;
    prod_q     <= prod_d;
    row_page_q <= row_page_d;
    h_q        <= h_d;
    w_q        <= w_d;
    slot_q     <= slot_d;
    out_we_q   <= out_we_d;
    out_page_q <= out_page_d;
    out_slot_q <= out_slot_d;
    out_last_q <= out_last_d;
    out_job_q  <= out_job_d;
  end

  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign status_o.tile_last = tile_last;

  assign out_valid_o = out_valid_q;
  assign out_we_o    = out_we_q;
  assign out_page_o  = out_page_q;
  assign out_slot_o  = out_slot_q;
  assign out_last_o  = out_last_q;
  assign out_job_o   = out_job_q;

  `ASSERT_IMPLY(a_last_slot, clk_i, rst_ni, out_valid_q && out_last_q,
                out_slot_q == SLOT_W'(SUB_H * SUB_W - 1), "last flag on wrong slot")
  `ASSERT_IMPLY(a_done_on_last, clk_i, rst_ni, out_valid_q && out_job_q, out_last_q,
                "job done without subblock last")
  `ASSERT_IMPLY(a_page_gated, clk_i, rst_ni, out_valid_q && !out_we_q,
                out_page_q == '0, "page not zero on a skipped tile")

endmodule

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the tile write-back address generator. A shadow walk
// in the bench tracks batch, block and subblock counters and predicts each
// tile address beat. Directed subblocks cover reset values, edge tiles, zero
// counts, small blocks and field extremes; random phases then reprogram the
// walk and drive subblocks with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import btwag_pkg::*;

  localparam int unsigned SUB_H = 2;
  localparam int unsigned SUB_W = 4;
  localparam longint unsigned PAGE_MASK = (64'd1 << PAGE_W) - 64'd1;
  localparam int unsigned BLK_IDX_MASK = (1 << 17) - 1;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned RANDOM_SUBBLOCKS = 420;

  typedef struct packed {
    logic              write_enable;
    logic [PAGE_W-1:0] page_id;
    logic [SLOT_W-1:0] slot_index;
    logic              subblock_last;
    logic              job_done;
  } tile_addr_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [47:0]           m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  blocked_tile_writeback_address_gen #(
    .SUB_H(SUB_H),
    .SUB_W(SUB_W)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i)
  );

  // shadow copy of the registers and the walk
  cfg_t            walk_cfg;
  int unsigned     batch_idx, blk_idx, sb_row, sb_col;
  longint unsigned batch_base, row_origin, col_origin;

  tile_addr_t  pending_tiles[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned sender_max_gap = 19;
  int unsigned receiver_max_stall = 19;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic int unsigned at_least_one(int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function void place_block();
    int unsigned bpr;
    bpr = at_least_one(32'(walk_cfg.blocks_per_row));
    row_origin = 64'(blk_idx / bpr) * 64'(walk_cfg.block_height);
    col_origin = 64'(blk_idx % bpr) * 64'(walk_cfg.block_width);
  endfunction

  function void place_batch();
    batch_base = (64'(batch_idx) * 64'(walk_cfg.tile_rows_total)
                  * 64'(walk_cfg.tile_cols_total)) & PAGE_MASK;
  endfunction

  function void restart_walk();
    batch_idx = 0;
    sb_row = 0;
    sb_col = 0;
    blk_idx = 32'(walk_cfg.first_block);
    place_batch();
    place_block();
  endfunction

  function void apply_reg(cfg_reg_e r, logic [CFG_DATA_W-1:0] d);
    case (r)
      CFG_TILE_ROWS:   walk_cfg.tile_rows_total = d[TDIM_W-1:0];
      CFG_TILE_COLS:   walk_cfg.tile_cols_total = d[TDIM_W-1:0];
      CFG_BATCHES:     walk_cfg.batch_count = d[BDIM_W-1:0];
      CFG_BLK_HEIGHT:  walk_cfg.block_height = d[BDIM_W-1:0];
      CFG_BLK_WIDTH:   walk_cfg.block_width = d[BDIM_W-1:0];
      CFG_BLK_PER_ROW: walk_cfg.blocks_per_row = d[TDIM_W-1:0];
      CFG_FIRST_BLK:   walk_cfg.first_block = d[BIDX_W-1:0];
      CFG_BLK_COUNT:   walk_cfg.block_count = d[BIDX_W-1:0];
      default: ;
    endcase
    restart_walk();
  endfunction

  // tile addresses of the current subblock, then step the walk
  function void predict_tile_addresses();
    int unsigned     rows_lim, cols_lim, blk_off, k;
    bit              col_end, row_end, blk_end, bat_end, done;
    longint unsigned m, n;
    tile_addr_t      t;
    rows_lim = at_least_one(32'(walk_cfg.block_height) / SUB_H);
    cols_lim = at_least_one(32'(walk_cfg.block_width) / SUB_W);
    blk_off = (blk_idx - 32'(walk_cfg.first_block)) & BLK_IDX_MASK;
    col_end = sb_col + 1 >= cols_lim;
    row_end = sb_row + 1 >= rows_lim;
    blk_end = blk_off + 1 >= at_least_one(32'(walk_cfg.block_count));
    bat_end = batch_idx + 1 >= at_least_one(32'(walk_cfg.batch_count));
    done = col_end && row_end && blk_end && bat_end;
    k = 0;
    for (int unsigned h = 0; h < SUB_H; h++) begin
      m = row_origin + 64'(sb_row) * SUB_H + h;
      for (int unsigned w = 0; w < SUB_W; w++) begin
        n = col_origin + 64'(sb_col) * SUB_W + w;
        t.write_enable = (m < 64'(walk_cfg.tile_rows_total)) &&
                         (n < 64'(walk_cfg.tile_cols_total));
        t.page_id = t.write_enable ?
          PAGE_W'((batch_base + m * 64'(walk_cfg.tile_cols_total) + n) & PAGE_MASK) : '0;
        t.slot_index = SLOT_W'(k);
        t.subblock_last = (h == SUB_H - 1) && (w == SUB_W - 1);
        t.job_done = t.subblock_last && done;
        pending_tiles.push_back(t);
        k++;
      end
    end
    if (!col_end) begin
      sb_col++;
    end else begin
      sb_col = 0;
      if (!row_end) begin
        sb_row++;
      end else begin
        sb_row = 0;
        if (!blk_end) begin
          blk_idx = (blk_idx + 1) & BLK_IDX_MASK;
        end else begin
          blk_idx = 32'(walk_cfg.first_block);
          batch_idx = bat_end ? 0 : batch_idx + 1;
          place_batch();
        end
        place_block();
      end
    end
  endfunction

  // called and returns at a falling edge
  task automatic send_subblock(input bit ready);
    int unsigned gap;
    gap = $urandom_range(0, sender_max_gap);
    repeat (gap) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {7'b0, ready};
    do @(posedge clk_i); while (!s_axis_tready);
    if (ready) predict_tile_addresses();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_tiles.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e r, input logic [CFG_DATA_W-1:0] d);
    wait_drained();
    // an idle beat may still be in flight inside the block
    repeat (20) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_addr_i = r;
    cfg_data_i = d;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(r, d);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic write_walk(input int unsigned rows, input int unsigned cols,
                            input int unsigned batches, input int unsigned bh,
                            input int unsigned bw, input int unsigned bpr,
                            input int unsigned first, input int unsigned count);
    write_reg(CFG_TILE_ROWS, CFG_DATA_W'(rows));
    write_reg(CFG_TILE_COLS, CFG_DATA_W'(cols));
    write_reg(CFG_BATCHES, CFG_DATA_W'(batches));
    write_reg(CFG_BLK_HEIGHT, CFG_DATA_W'(bh));
    write_reg(CFG_BLK_WIDTH, CFG_DATA_W'(bw));
    write_reg(CFG_BLK_PER_ROW, CFG_DATA_W'(bpr));
    write_reg(CFG_FIRST_BLK, CFG_DATA_W'(first));
    write_reg(CFG_BLK_COUNT, CFG_DATA_W'(count));
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_reg_value(cfg_reg_e r);
    int unsigned width;
    case (r)
      CFG_TILE_ROWS, CFG_TILE_COLS, CFG_BLK_PER_ROW: width = TDIM_W;
      CFG_FIRST_BLK, CFG_BLK_COUNT:                  width = BIDX_W;
      default:                                       width = BDIM_W;
    endcase
    // now and then the whole field range, mostly small walks that wrap
    if ($urandom_range(0, 7) == 0) return CFG_DATA_W'($urandom & ((1 << width) - 1));
    if ($urandom_range(0, 15) == 0) return CFG_DATA_W'((1 << width) - 1);
    case (r)
      CFG_TILE_ROWS, CFG_TILE_COLS: return CFG_DATA_W'($urandom_range(0, 14));
      CFG_BATCHES:                  return CFG_DATA_W'($urandom_range(0, 3));
      CFG_BLK_HEIGHT:               return CFG_DATA_W'($urandom_range(0, 6));
      CFG_BLK_WIDTH:                return CFG_DATA_W'($urandom_range(0, 12));
      CFG_BLK_PER_ROW:              return CFG_DATA_W'($urandom_range(0, 4));
      CFG_FIRST_BLK:                return CFG_DATA_W'($urandom_range(0, 8));
      default:                      return CFG_DATA_W'($urandom_range(0, 4));
    endcase
  endfunction

  task automatic test_reset_walk();
    send_subblock(1'b1);
    send_subblock(1'b0);
    send_subblock(1'b1);
  endtask

  task automatic test_edge_tiles();
    // two batches of two blocks, the second block entirely past Mt
    write_walk(3, 5, 2, 4, 4, 2, 1, 2);
    repeat (8) send_subblock(1'b1);
  endtask

  task automatic test_zero_counts_small_blocks();
    write_walk(0, 7, 0, 1, 3, 0, 2, 0);
    repeat (2) send_subblock(1'b1);
    write_reg(CFG_TILE_ROWS, CFG_DATA_W'(9));
    repeat (2) send_subblock(1'b1);
  endtask

  task automatic test_field_extremes();
    write_walk(13'h1fff, 13'h1fff, 11'h7ff, 11'h7ff, 11'h7ff, 13'h1fff, 16'hffff, 16'hffff);
    repeat (3) send_subblock(1'b1);
    write_reg(CFG_FIRST_BLK, CFG_DATA_W'(0));
    repeat (3) send_subblock(1'b1);
  endtask

  task automatic test_random_walks();
    int unsigned sent, phase, len, pause_at;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_SUBBLOCKS) begin
      sender_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 19;
      receiver_max_stall = ($urandom_range(0, 3) == 0) ? 0 : 19;
      for (int r = 0; r < 8; r++) begin
        if ($urandom_range(0, 1) == 1) write_reg(cfg_reg_e'(r), pick_reg_value(cfg_reg_e'(r)));
      end
      len = $urandom_range(8, 40);
      pause_at = (phase == 1 || $urandom_range(0, 3) == 0) ? $urandom_range(1, len) : 0;
      for (int unsigned i = 1; i <= len; i++) begin
        if (i == pause_at) wait_drained();
        if ($urandom_range(0, 9) == 0) begin
          send_subblock(1'b0);
        end else begin
          send_subblock(1'b1);
          sent++;
        end
      end
      phase++;
    end
  endtask

  // result sink: fresh stall draw per beat
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      stall = $urandom_range(0, receiver_max_stall);
      repeat (stall) begin
        m_axis_tready = 1'b0;
        @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    tile_addr_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_tiles.size() == 0) begin
        $error("unexpected tile beat: page_id %0h", m_axis_tdata[PAGE_W-1:0]);
        mismatches++;
      end else begin
        want = pending_tiles[0];
        pending_tiles.delete(0);
        if (m_axis_tuser !== want.write_enable) begin
          $error("write_enable: expected %0b, got %0b", want.write_enable, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[PAGE_W-1:0] !== want.page_id) begin
          $error("page_id: expected %0h, got %0h", want.page_id, m_axis_tdata[PAGE_W-1:0]);
          mismatches++;
        end
        if (m_axis_tdata[PAGE_W+:SLOT_W] !== want.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want.slot_index,
                 m_axis_tdata[PAGE_W+:SLOT_W]);
          mismatches++;
        end
        if (m_axis_tlast !== want.subblock_last) begin
          $error("subblock_last: expected %0b, got %0b", want.subblock_last, m_axis_tlast);
          mismatches++;
        end
        if (m_axis_tdata[PAGE_W+SLOT_W] !== want.job_done) begin
          $error("job_done: expected %0b, got %0b", want.job_done,
                 m_axis_tdata[PAGE_W+SLOT_W]);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any beat on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("blocked_tile_writeback_address_gen test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_addr_i = CFG_TILE_ROWS;
    cfg_data_i = '0;
    walk_cfg = '{tile_rows_total: 1, tile_cols_total: 1, batch_count: 1, block_height: 2,
                 block_width: 4, blocks_per_row: 1, first_block: 0, block_count: 1};
    restart_walk();
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_walk();
    test_edge_tiles();
    test_zero_counts_small_blocks();
    test_field_extremes();
    test_random_walks();

    wait_drained();
    repeat (30) @(posedge clk_i);
    if (mismatches == 0 && pending_tiles.size() == 0) begin
      $display("blocked_tile_writeback_address_gen test passed");
    end else begin
      $display("blocked_tile_writeback_address_gen test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
